// ===== src/dip_pkg.sv =====
// Package for the decimal integer parser: result codes, parse phases,
// the word passed from the parse stage to the check stage, and ASCII constants.
// No dependencies.
package dip_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_NEGATIVE = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_SMALL    = 3'd5,
    ST_LARGE    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  // Snapshot of a finished number, handed from parse to check.
  typedef struct packed {
    logic        valid;
    logic        forced;         // status already decided in parse
    status_t     forced_status;
    logic        overflowed;
    logic        digit_seen;
    logic        negative;
    logic [63:0] acc;
    logic [7:0]  consumed;
  } fin_t;

  localparam int DEF_MAX_LENGTH = 255;

  localparam logic [1:0] REG_SIGNED_MODE = 2'd0;
  localparam logic [1:0] REG_MIN_BOUND   = 2'd1;
  localparam logic [1:0] REG_MAX_BOUND   = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  localparam logic [63:0] RADIX   = 64'd10;
  localparam logic [63:0] LIM_U   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_SP  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_SN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QUO_U   = LIM_U / RADIX;
  localparam logic [63:0] QUO_S   = LIM_SP / RADIX;
  localparam logic [3:0]  REM_U   = 4'(LIM_U % RADIX);
  localparam logic [3:0]  REM_SP  = 4'(LIM_SP % RADIX);
  localparam logic [3:0]  REM_SN  = 4'(LIM_SN % RADIX);

  localparam logic [63:0] SIGN_FLIP = 64'h8000_0000_0000_0000;

  localparam logic [63:0] RST_MIN_BOUND = 64'h8000_0000_0000_0000;
  localparam logic [63:0] RST_MAX_BOUND = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

// ===== src/decimal_integer_parser_top.sv =====
// Top level of the decimal integer parser: ports, configuration registers,
// input register and the three-register pipeline. Uses dip_pkg, dip_parse, dip_check.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+---------------------------------------
//  s_*     | in  | s_tvalid / s_tready        | tdata char_byte, tuser first_char,
//          |     |                            | tlast last_char
//  m_*     | out | m_tvalid / m_tready        | tdata status, value, consumed
//  cfg_*   | in  | cfg_we (no wait)           | cfg_index, cfg_data
//
// One character enters per cycle while not stalled; the multiply-by-ten accumulate
// closes its loop within the parse stage, so the sustained rate is one word per clock.
// A result leaves through the input register, the parse snapshot register and the
// check/result register after its closing character is accepted.
// The whole pipeline advances together; it stalls only while the result register
// is full and m_tready is low, and s_tready drops for exactly those cycles.
// rst is synchronous: it closes any open string, empties the pipeline and loads
// the default signed mode and full signed 64-bit bounds.
module decimal_integer_parser_top #(
  parameter int MAX_LENGTH = dip_pkg::DEF_MAX_LENGTH
) (
  input  logic        clk,
  input  logic        rst,
  // input characters
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tuser,   // [0] first_char
  input  logic        s_tlast,   // last_char
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [2:0] status, [66:3] value, [74:67] consumed, rest 0
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import dip_pkg::*;

  logic        signed_mode;
  logic [63:0] min_bound, max_bound;

  logic        adv;
  logic        in_valid;
  logic [7:0]  in_char;
  logic        in_first, in_last;

  fin_t        fin;
  status_t     out_status;
  logic [63:0] out_value;
  logic [7:0]  out_consumed;

  // Advance the pipeline whenever the result register is empty or being taken.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b1;
      min_bound   <= RST_MIN_BOUND;
      max_bound   <= RST_MAX_BOUND;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIGNED_MODE: signed_mode <= cfg_data[0];
        REG_MIN_BOUND:   min_bound   <= cfg_data;
        REG_MAX_BOUND:   max_bound   <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s_tvalid) begin
      in_char  <= s_tdata;
      in_first <= s_tuser;
      in_last  <= s_tlast;
    end
  end

  dip_parse #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .in_char    (in_char),
    .in_first   (in_first),
    .in_last    (in_last),
    .signed_mode(signed_mode),
    .fin        (fin)
  );

  dip_check u_check (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .fin         (fin),
    .signed_mode (signed_mode),
    .min_bound   (min_bound),
    .max_bound   (max_bound),
    .out_valid   (m_tvalid),
    .out_status  (out_status),
    .out_value   (out_value),
    .out_consumed(out_consumed)
  );

  assign m_tdata = {5'd0, out_consumed, out_value, out_status};

`ifndef SYNTHESIS
  // Any error result carries a zero value and zero length.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status != ST_OK)) |-> ((out_value == 64'd0) && (out_consumed == 8'd0)))
    else $error("error result with nonzero payload");

  // A good result always consumed at least one digit.
  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status == ST_OK)) |-> (out_consumed != 8'd0))
    else $error("ok result with zero length");

  // A stalled input word stays in the input register.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !adv) |=> (in_valid && $stable(in_char)))
    else $error("input word lost during stall");
`endif

endmodule

// ===== src/dip_parse.sv =====
// Parse stage: per-string state, multiply-by-ten accumulate with overflow
// check, and the registered snapshot of each finished number. Uses dip_pkg.
module dip_parse #(
  parameter int MAX_LENGTH = dip_pkg::DEF_MAX_LENGTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [7:0]    in_char,
  input  logic          in_first,
  input  logic          in_last,
  input  logic          signed_mode,
  output dip_pkg::fin_t fin
);
  import dip_pkg::*;

  localparam int LEN_W = $clog2(MAX_LENGTH + 1);

  phase_t            phase, phase_next;
  logic              negative, negative_next;
  logic [63:0]       acc, acc_next;
  logic              overflowed, overflowed_next;
  logic              digit_seen, digit_seen_next;
  logic [LEN_W-1:0]  len, len_next;
  fin_t              fin_next;

  logic              base_neg, base_ovf;
  logic [63:0]       base_acc, acc_mac, quo;
  logic [LEN_W-1:0]  base_len, len_inc;
  logic [3:0]        dval, rem;
  logic              is_digit, is_sign, too_big, take_digit, unsigned_minus;

  assign is_digit = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign is_sign  = (in_char == CH_MINUS) || (in_char == CH_PLUS);
  assign dval     = in_char[3:0];
  assign unsigned_minus = negative && !signed_mode;

  // A first character starts from cleared state.
  assign base_neg = in_first ? 1'b0 : negative;
  assign base_ovf = in_first ? 1'b0 : overflowed;
  assign base_acc = in_first ? 64'd0 : acc;
  assign base_len = in_first ? '0 : len;

  assign len_inc = (base_len == LEN_W'(MAX_LENGTH)) ? base_len : base_len + 1'b1;

  always_comb begin
    if (signed_mode) begin
      quo = QUO_S;
      rem = base_neg ? REM_SN : REM_SP;
    end else begin
      quo = QUO_U;
      rem = REM_U;
    end
  end

  assign too_big = (base_acc > quo) || ((base_acc == quo) && (dval > rem));
  assign acc_mac = {base_acc[60:0], 3'b000} + {base_acc[62:0], 1'b0} + {60'd0, dval};

  always_comb begin
    take_digit = 1'b0;
    if (in_valid) begin
      if (in_first) begin
        take_digit = is_digit;
      end else begin
        case (phase)
          PH_SIGN:   take_digit = is_digit && !(unsigned_minus && (in_char != CH_ZERO));
          PH_DIGITS: take_digit = is_digit;
          default:   take_digit = 1'b0;
        endcase
      end
    end
  end

  // Data state
  always_comb begin
    negative_next   = negative;
    acc_next        = acc;
    overflowed_next = overflowed;
    digit_seen_next = digit_seen;
    len_next        = len;
    if (in_valid && in_first) begin
      negative_next   = 1'b0;
      acc_next        = 64'd0;
      overflowed_next = 1'b0;
      digit_seen_next = 1'b0;
      len_next        = '0;
      if (is_sign) begin
        negative_next = (in_char == CH_MINUS);
        len_next      = len_inc;
      end
    end
    if (take_digit) begin
      digit_seen_next = 1'b1;
      len_next        = len_inc;
      if (!base_ovf) begin
        if (too_big) begin
          overflowed_next = 1'b1;
        end else begin
          acc_next = acc_mac;
        end
      end
    end
  end

  // Finished-number snapshot
  always_comb begin
    fin_next               = '0;
    fin_next.forced_status = ST_OK;
    fin_next.overflowed    = overflowed_next;
    fin_next.digit_seen    = digit_seen_next;
    fin_next.negative      = negative_next;
    fin_next.acc           = acc_next;
    fin_next.consumed      = (32'(len_next) > 32'd255) ? 8'd255 : 8'(len_next);
    if (in_valid) begin
      if (in_first) begin
        if (is_digit) begin
          fin_next.valid = in_last;
        end else if (is_sign) begin
          fin_next.valid = in_last;
          if ((in_char == CH_MINUS) && !signed_mode) begin
            fin_next.forced        = 1'b1;
            fin_next.forced_status = ST_NEGATIVE;
          end
        end else begin
          fin_next.valid         = 1'b1;
          fin_next.forced        = 1'b1;
          fin_next.forced_status = ST_INVALID;
        end
      end else begin
        case (phase)
          PH_SIGN: begin
            if (unsigned_minus && (in_char != CH_ZERO)) begin
              fin_next.valid         = 1'b1;
              fin_next.forced        = 1'b1;
              fin_next.forced_status = ST_NEGATIVE;
            end else begin
              fin_next.valid = !is_digit || in_last;
            end
          end
          PH_DIGITS: fin_next.valid = !is_digit || in_last;
          default:   fin_next.valid = 1'b0;
        endcase
      end
    end
  end

  // Phase
  always_comb begin
    phase_next = phase;
    if (in_valid) begin
      if (fin_next.valid) begin
        phase_next = PH_IDLE;
      end else if (in_first) begin
        phase_next = is_digit ? PH_DIGITS : PH_SIGN;
      end else begin
        case (phase)
          PH_SIGN:   phase_next = PH_DIGITS;
          PH_DIGITS: phase_next = PH_DIGITS;
          default:   phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      negative   <= 1'b0;
      acc        <= 64'd0;
      overflowed <= 1'b0;
      digit_seen <= 1'b0;
      len        <= '0;
      fin        <= '0;
    end else if (adv) begin
      phase      <= phase_next;
      negative   <= negative_next;
      acc        <= acc_next;
      overflowed <= overflowed_next;
      digit_seen <= digit_seen_next;
      len        <= len_next;
      fin        <= fin_next;
    end
  end

endmodule

// ===== src/dip_check.sv =====
// Check stage: apply the sign, compare against the bounds, pick the status
// and hold the result register. Uses dip_pkg.
module dip_check (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  dip_pkg::fin_t    fin,
  input  logic             signed_mode,
  input  logic [63:0]      min_bound,
  input  logic [63:0]      max_bound,
  output logic             out_valid,
  output dip_pkg::status_t out_status,
  output logic [63:0]      out_value,
  output logic [7:0]       out_consumed
);
  import dip_pkg::*;

  logic [63:0] v, flip;
  logic        below_min, above_max;
  status_t     status_next;
  logic [63:0] value_next;
  logic [7:0]  consumed_next;

  assign v         = fin.negative ? (64'd0 - fin.acc) : fin.acc;
  assign flip      = signed_mode ? SIGN_FLIP : 64'd0;
  assign below_min = (v ^ flip) < (min_bound ^ flip);
  assign above_max = (v ^ flip) > (max_bound ^ flip);

  always_comb begin
    value_next    = 64'd0;
    consumed_next = 8'd0;
    if (fin.forced) begin
      status_next = fin.forced_status;
    end else if (fin.overflowed) begin
      status_next = ST_OVERFLOW;
    end else if (!fin.digit_seen) begin
      status_next = ST_EMPTY;
    end else if (below_min) begin
      status_next = ST_SMALL;
    end else if (above_max) begin
      status_next = ST_LARGE;
    end else begin
      status_next   = ST_OK;
      value_next    = v;
      consumed_next = fin.consumed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin.valid) begin
      out_status   <= status_next;
      out_value    <= value_next;
      out_consumed <= consumed_next;
    end
  end

endmodule
